/* sv/cau_pkg.sv */
// Package for the complex arithmetic unit: word widths, item types and the
// divider cell types. Depends on nothing.
package cau_pkg;

  localparam int W       = 32;
  localparam int F       = 16;
  localparam int PROD_W  = 2 * W;
  localparam int SUM_W   = 2 * W + 1;
  localparam int MAG_W   = 2 * W + 1;
  localparam int DEN_W   = 2 * W + 1;
  localparam int NUM_W   = MAG_W + F;
  localparam int REM_W   = DEN_W;
  localparam int N_CELLS = NUM_W;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } cau_mode_t;

  typedef struct packed {
    cau_mode_t             mode;
    logic signed [W-1:0]   first_real;
    logic signed [W-1:0]   first_imag;
    logic signed [W-1:0]   second_real;
    logic signed [W-1:0]   second_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [W-1:0]   result_real;
    logic signed [W-1:0]   result_imag;
    logic                  overflow;
    logic                  divide_by_zero;
  } cau_out_t;

  typedef struct packed {
    logic               neg;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   rem;
    logic [W-1:0]       q;
    logic               hi;
  } cau_lane_t;

  typedef struct packed {
    logic               pass;
    logic               dz;
    logic [DEN_W-1:0]   den;
    cau_lane_t          re;
    cau_lane_t          im;
  } cau_cell_t;

endpackage

/* sv/cau_front.sv */
// Operand stages of the complex arithmetic unit: products, sums and the
// set-up of the divider chain. Depends on cau_pkg.
module cau_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  cau_pkg::cau_in_t in_data,
  output logic             out_valid,
  output cau_pkg::cau_cell_t out_cell
);
  import cau_pkg::*;

  logic                     v1_r;
  cau_mode_t                mode_r;
  logic signed [PROD_W-1:0] ac_r, bd_r, bc_r, ad_r, cc_r, dd_r;
  logic signed [W:0]        sre_r, sim_r;
  logic                     v2_r;
  cau_cell_t                cell_r, cell_nxt;

  logic signed [SUM_W-1:0]  re_s, im_s;
  logic [DEN_W-1:0]         den;

  function automatic cau_lane_t mk_lane(input cau_mode_t m, input logic signed [SUM_W-1:0] s);
    cau_lane_t        l;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] sh;
    l     = '0;
    l.neg = s[SUM_W-1];
    mag   = l.neg ? MAG_W'(-s) : MAG_W'(s);
    sh    = (m == MODE_MUL) ? (mag >> F) : mag;
    if (m == MODE_DIV) begin
      l.num = NUM_W'(mag) << F;
    end else begin
      l.q  = sh[W-1:0];
      l.hi = |sh[MAG_W-1:W];
    end
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= in_data.mode;
    ac_r   <= in_data.first_real * in_data.second_real;
    bd_r   <= in_data.first_imag * in_data.second_imag;
    bc_r   <= in_data.first_imag * in_data.second_real;
    ad_r   <= in_data.first_real * in_data.second_imag;
    cc_r   <= in_data.second_real * in_data.second_real;
    dd_r   <= in_data.second_imag * in_data.second_imag;
    if (in_data.mode == MODE_SUB) begin
      sre_r <= (W+1)'(in_data.first_real) - (W+1)'(in_data.second_real);
      sim_r <= (W+1)'(in_data.first_imag) - (W+1)'(in_data.second_imag);
    end else begin
      sre_r <= (W+1)'(in_data.first_real) + (W+1)'(in_data.second_real);
      sim_r <= (W+1)'(in_data.first_imag) + (W+1)'(in_data.second_imag);
    end
    cell_r <= cell_nxt;
  end

  always_comb begin
    den = DEN_W'(cc_r) + DEN_W'(dd_r);
    unique case (mode_r)
      MODE_ADD, MODE_SUB: begin
        re_s = SUM_W'(sre_r);
        im_s = SUM_W'(sim_r);
      end
      MODE_MUL: begin
        re_s = SUM_W'(ac_r) - SUM_W'(bd_r);
        im_s = SUM_W'(bc_r) + SUM_W'(ad_r);
      end
      default: begin
        re_s = SUM_W'(ac_r) + SUM_W'(bd_r);
        im_s = SUM_W'(bc_r) - SUM_W'(ad_r);
      end
    endcase
    cell_nxt.dz   = (mode_r == MODE_DIV) && (den == '0);
    cell_nxt.pass = (mode_r != MODE_DIV) || cell_nxt.dz;
    cell_nxt.den  = den;
    cell_nxt.re   = mk_lane(mode_r, re_s);
    cell_nxt.im   = mk_lane(mode_r, im_s);
    if (cell_nxt.dz) begin
      cell_nxt.re = '0;
      cell_nxt.im = '0;
    end
  end

  assign out_valid = v2_r;
  assign out_cell  = cell_r;

endmodule

/* sv/cau_div_cell.sv */
// One restoring-division cell: unless the item is marked pass, takes one numerator bit
// on each of the two lanes and hands the partial result on. Depends on cau_pkg.
module cau_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cau_pkg::cau_cell_t in_cell,
  output logic               out_valid,
  output cau_pkg::cau_cell_t out_cell
);
  import cau_pkg::*;

  logic      valid_r;
  cau_cell_t cell_r, cell_nxt;

  function automatic cau_lane_t step(input cau_lane_t l, input logic [DEN_W-1:0] d);
    cau_lane_t      r;
    logic [REM_W:0] rsh;
    logic [REM_W:0] diff;
    logic           ge;
    rsh   = {l.rem, l.num[NUM_W-1]};
    diff  = rsh - {1'b0, d};
    ge    = rsh >= {1'b0, d};
    r     = l;
    r.rem = ge ? diff[REM_W-1:0] : rsh[REM_W-1:0];
    r.num = l.num << 1;
    r.q   = {l.q[W-2:0], ge};
    r.hi  = l.hi | l.q[W-1];
    return r;
  endfunction

  always_comb begin
    cell_nxt = in_cell;
    if (!in_cell.pass) begin
      cell_nxt.re = step(in_cell.re, in_cell.den);
      cell_nxt.im = step(in_cell.im, in_cell.den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

/* sv/complex_arithmetic_unit.sv */
// Complex arithmetic unit top level: operand stages, the divider cell chain
// and the saturating output register. Depends on cau_pkg, cau_front, cau_div_cell.
// In every mode an item passes the operand stages, the 81 cells and the output register.
// Throughput: one item per cycle; busy is never raised, as the chain of 81 cells moves each cycle.
// Reset clears only the valid flags; no item survives reset.
module complex_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  logic      v_chain [N_CELLS+1];
  cau_cell_t c_chain [N_CELLS+1];
  logic      out_valid_r;
  cau_out_t  out_r, out_nxt;
  logic      ovf_re, ovf_im;

  function automatic logic [W-1:0] sat(input cau_lane_t l, output logic ovf);
    logic big;
    big = l.hi | (l.q[W-1] & (!l.neg | (|l.q[W-2:0])));
    ovf = big;
    if (big) begin
      return l.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return l.neg ? -l.q : l.q;
  endfunction

  assign busy = 1'b0;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (v_chain[0]),
    .out_cell  (c_chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_chain[i]),
      .in_cell   (c_chain[i]),
      .out_valid (v_chain[i+1]),
      .out_cell  (c_chain[i+1])
    );
  end

  always_comb begin
    out_nxt.result_real    = sat(c_chain[N_CELLS].re, ovf_re);
    out_nxt.result_imag    = sat(c_chain[N_CELLS].im, ovf_im);
    out_nxt.overflow       = ovf_re | ovf_im;
    out_nxt.divide_by_zero = c_chain[N_CELLS].dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_chain[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      out_data.result_real == '0 && out_data.result_imag == '0 && !out_data.overflow)
    else $error("divide by zero result not cleared");

  a_chain_in: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 v_chain[0])
    else $error("accepted item missing at head of cell chain");

  a_chain_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_chain[N_CELLS] |=> out_valid)
    else $error("item lost at end of cell chain");

  a_pass_dz: assert property (@(posedge clk) disable iff (!rst_n)
    v_chain[0] && c_chain[0].dz |-> c_chain[0].pass)
    else $error("zero divisor item entered the divider");

endmodule
